// ===== hw/rtl/bpq_pkg.sv =====
// bpq_pkg: command, status and place codes shared by the buffer pool queue core
// no dependencies
package bpq_pkg;

  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TAKE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DROP    = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] AT_FREE   = 2'd0;
  localparam logic [1:0] AT_HELD   = 2'd1;
  localparam logic [1:0] AT_ACTIVE = 2'd2;

endpackage

// ===== hw/rtl/bpq_ram.sv =====
// bpq_ram: generic simple dual port ram, one write and one read port, with registered read
// no dependencies
module bpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/buffer_pool_typed_queue_core.sv =====
// buffer_pool_typed_queue_core: free stack and typed active fifo over one link memory
// uses bpq_pkg and bpq_ram
//
//  channel | signals                                             | dir
//  in      | in_valid in_stall cmd slot_index elem_type match_any |
//          | drop_limit                                           | to core
//  out     | out_valid out_stall status out_index out_type dropped|
//          | active_count free_count                              | from core
//
// after reset a clearing pass writes all link, type and place entries
// allocate and release go through dispatch, read wait and read done to the result, or
// straight to the result when refused early; append also relinks a non-empty old tail
// take and drop walk the active list: walk read, walk wait and check for each visited slot,
// relink and mark for each removed slot, and at the end the result is handed over
// one item at a time; in_stall is high from acceptance until the result is taken
// out_stall holds the result and everything behind it
module buffer_pool_typed_queue_core #(
  parameter int POOL_DEPTH = 64,
  parameter int TYPE_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] cmd,
  input  logic [5:0] slot_index,
  input  logic [7:0] elem_type,
  input  logic       match_any,
  input  logic [6:0] drop_limit,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [5:0] out_index,
  output logic [7:0] out_type,
  output logic [6:0] dropped,
  output logic [6:0] active_count,
  output logic [6:0] free_count
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int LW = AW + 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int MW = LW + TYPE_WIDTH + 2;
  localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_RD_WAIT, S_RD_DONE, S_WALK_RD, S_WALK_WAIT,
    S_WALK_CHK, S_FIX_PREV, S_RD_WAIT_FIX, S_FIX_CUR, S_MARK, S_RESULT
  } state_t;

  state_t state;
  logic [2:0] c_cmd;
  logic [LW-1:0] c_idx;
  logic [TYPE_WIDTH-1:0] c_type;
  logic c_any;
  logic [6:0] c_limit;
  logic [LW-1:0] free_head, active_head, active_tail, prev, cur;
  logic [CW-1:0] active_total, free_total;
  logic [6:0] drop_n;
  logic [AW-1:0] clr;
  logic [AW-1:0] raddr;
  logic [MW-1:0] rdata;
  logic we;
  logic [AW-1:0] waddr;
  logic [MW-1:0] wdata;
  logic [TYPE_WIDTH-1:0] hit_type;
  logic [LW-1:0] hit_next;

  // entry word: {place, type, link}
  logic [LW-1:0] r_link;
  logic [TYPE_WIDTH-1:0] r_type;
  logic [1:0] r_where;
  assign r_link = rdata[LW-1:0];
  assign r_type = rdata[LW +: TYPE_WIDTH];
  assign r_where = rdata[MW-1 -: 2];

  bpq_ram #(.WIDTH(MW), .DEPTH(POOL_DEPTH)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [6:0] sat7(input logic [CW-1:0] v);
    if (CW > 7 && v > CW'(127)) return 7'd127;
    return 7'(v);
  endfunction

  logic idx_ok, is_typed_drop;
  assign idx_ok = {1'b0, slot_index} < 7'(POOL_DEPTH) || (LW > 7);
  assign is_typed_drop = (c_cmd == bpq_pkg::CMD_DROP);

  // walk read address and write port come from the sequencer
  always_comb begin
    we = 1'b0;
    waddr = cur[AW-1:0];
    wdata = '0;
    raddr = cur[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr;
        wdata = {bpq_pkg::AT_FREE, {TYPE_WIDTH{1'b0}},
                 (clr == '0) ? NIL : LW'(clr) - LW'(1)};
      end
      // address held through dispatch and read wait for the registered read
      S_DISPATCH, S_RD_WAIT:
        raddr = (c_cmd == bpq_pkg::CMD_ALLOC) ? free_head[AW-1:0] : c_idx[AW-1:0];
      S_RD_DONE: begin
        unique case (c_cmd)
          bpq_pkg::CMD_ALLOC: begin
            we = 1'b1; waddr = free_head[AW-1:0];
            wdata = {bpq_pkg::AT_HELD, {TYPE_WIDTH{1'b0}}, NIL};
          end
          bpq_pkg::CMD_APPEND: begin
            we = (r_where == bpq_pkg::AT_HELD) && (active_total < CW'(POOL_DEPTH));
            waddr = c_idx[AW-1:0];
            wdata = {bpq_pkg::AT_ACTIVE, c_type, NIL};
          end
          bpq_pkg::CMD_RELEASE: begin
            we = (r_where == bpq_pkg::AT_HELD); waddr = c_idx[AW-1:0];
            wdata = {bpq_pkg::AT_FREE, {TYPE_WIDTH{1'b0}}, free_head};
          end
          default: ;
        endcase
      end
      S_FIX_PREV, S_RD_WAIT_FIX: raddr = prev[AW-1:0];
      S_FIX_CUR: begin
        // prev entry is now in rdata; relink it past cur, or to the new slot on append
        we = (prev != NIL); waddr = prev[AW-1:0];
        wdata = {r_where, r_type, c_idx};
      end
      S_MARK: begin
        // taken slot becomes held, dropped slot goes on the free stack
        we = 1'b1; waddr = cur[AW-1:0];
        if (c_cmd == bpq_pkg::CMD_TAKE) wdata = {bpq_pkg::AT_HELD, hit_type, NIL};
        else wdata = {bpq_pkg::AT_FREE, {TYPE_WIDTH{1'b0}}, free_head};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      free_head <= LW'(POOL_DEPTH - 1);
      active_head <= NIL;
      active_tail <= NIL;
      active_total <= '0;
      free_total <= CW'(POOL_DEPTH);
      out_valid <= 1'b0;
      in_stall <= 1'b1;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(POOL_DEPTH - 1)) begin
            state <= S_IDLE;
            in_stall <= 1'b0;
          end
        end
        S_IDLE: if (in_valid) begin
          c_cmd <= cmd;
          c_idx <= LW'(slot_index);
          c_type <= TYPE_WIDTH'(elem_type);
          c_any <= match_any;
          c_limit <= drop_limit;
          drop_n <= '0;
          status <= (cmd == bpq_pkg::CMD_DROP) ? bpq_pkg::ST_OK : bpq_pkg::ST_NONE;
          out_index <= '0;
          out_type <= '0;
          in_stall <= 1'b1;
          unique case (cmd)
            bpq_pkg::CMD_ALLOC:
              state <= (free_head == NIL) ? S_RESULT : S_DISPATCH;
            bpq_pkg::CMD_APPEND, bpq_pkg::CMD_RELEASE:
              state <= idx_ok ? S_DISPATCH : S_RESULT;
            bpq_pkg::CMD_TAKE, bpq_pkg::CMD_DROP: begin
              prev <= NIL;
              cur <= active_head;
              state <= (cmd == bpq_pkg::CMD_DROP && drop_limit == '0) ? S_RESULT : S_WALK_RD;
            end
            default: state <= S_RESULT;
          endcase
        end
        S_DISPATCH: state <= S_RD_WAIT;
        S_RD_WAIT: state <= S_RD_DONE;
        S_RD_DONE: begin
          // link old tail to the new slot when the list is not empty
          state <= (c_cmd == bpq_pkg::CMD_APPEND && r_where == bpq_pkg::AT_HELD &&
                    active_total < CW'(POOL_DEPTH) && active_tail != NIL) ?
                   S_FIX_PREV : S_RESULT;
          unique case (c_cmd)
            bpq_pkg::CMD_ALLOC: begin
              free_head <= r_link;
              free_total <= free_total - CW'(1);
              status <= bpq_pkg::ST_OK;
              out_index <= 6'(free_head);
            end
            bpq_pkg::CMD_APPEND: if (r_where == bpq_pkg::AT_HELD) begin
              if (active_total >= CW'(POOL_DEPTH)) status <= bpq_pkg::ST_FULL;
              else begin
                status <= bpq_pkg::ST_OK;
                active_total <= active_total + CW'(1);
                active_tail <= c_idx;
                if (active_tail == NIL) active_head <= c_idx;
                else prev <= active_tail;
              end
            end
            bpq_pkg::CMD_RELEASE: if (r_where == bpq_pkg::AT_HELD) begin
              status <= bpq_pkg::ST_OK;
              free_head <= c_idx;
              free_total <= free_total + CW'(1);
            end
            default: ;
          endcase
        end
        S_WALK_RD: state <= (cur == NIL) ? S_RESULT : S_WALK_WAIT;
        S_WALK_WAIT: state <= S_WALK_CHK;
        S_WALK_CHK: begin
          if ((c_any && !is_typed_drop) || r_type == c_type) begin
            hit_type <= r_type;
            hit_next <= r_link;
            if (cur == active_tail) active_tail <= prev;
            active_total <= active_total - CW'(1);
            if (prev == NIL) begin
              active_head <= r_link;
              state <= S_FIX_CUR;
            end else begin
              c_idx <= r_link;
              state <= S_FIX_PREV;
            end
          end else begin
            prev <= cur;
            cur <= r_link;
            state <= S_WALK_RD;
          end
        end
        S_FIX_PREV: state <= S_RD_WAIT_FIX;
        S_RD_WAIT_FIX: state <= S_FIX_CUR;
        S_FIX_CUR: begin
          if (c_cmd == bpq_pkg::CMD_APPEND) state <= S_RESULT;
          else if (c_cmd == bpq_pkg::CMD_TAKE) begin
            status <= bpq_pkg::ST_OK;
            out_index <= 6'(cur);
            out_type <= 8'(hit_type);
            state <= S_MARK;
          end else begin
            drop_n <= drop_n + 7'd1;
            state <= S_MARK;
          end
        end
        S_MARK: begin
          if (c_cmd == bpq_pkg::CMD_TAKE) state <= S_RESULT;
          else begin
            free_head <= cur;
            free_total <= free_total + CW'(1);
            cur <= hit_next;
            state <= (drop_n == c_limit) ? S_RESULT : S_WALK_RD;
          end
        end
        S_RESULT: if (!out_valid) begin
          dropped <= drop_n;
          active_count <= sat7(active_total);
          free_count <= sat7(free_total);
          out_valid <= 1'b1;
        end else if (!out_stall) begin
          out_valid <= 1'b0;
          in_stall <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({status, out_index, out_type, dropped, active_count, free_count}));

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall);

  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> in_stall && !out_valid);

  a_counts: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, active_total} + {1'b0, free_total}) <= (CW+1)'(POOL_DEPTH));

endmodule
